// ----- design/pmq_pkg.sv -----
`timescale 1ns / 1ps

package pmq_pkg;

   localparam int SLOTS_DEF     = 32;
   localparam int MAX_BYTES_DEF = 256;

   localparam int PRIO_W     = 15;
   localparam int LEN_W      = 9;
   localparam int PAY_W      = 32;
   localparam int BUF_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 6;
   localparam int MAXM_W     = 6;
   localparam int MSIZE_W    = 9;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_TOO_LONG  = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_TOO_SMALL = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_MESSAGES = 1'b0,
      CSR_MESSAGE_SIZE = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_ALLOC,
      S_WALK,
      S_LINK,
      S_LINK_PREV,
      S_RECV,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic decide;
      logic alloc;
      logic walk;
      logic link;
      logic link_prev;
      logic recv;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_recv;
      logic err;
      logic head_nil;
      logic walk_more;
      logic prev_nil;
      logic out_free;
   } flags_type;

endpackage

// ----- design/pmq_ctrl.sv -----
`timescale 1ns / 1ps

module pmq_ctrl
   import pmq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  flags_type flags,
   output cmd_type   cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (flags.err) begin
               state_in = S_RESP;
            end else if (flags.is_recv) begin
               state_in = S_RECV;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = flags.head_nil ? S_LINK : S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (!flags.walk_more) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = flags.prev_nil ? S_RESP : S_LINK_PREV;
         end
         S_LINK_PREV: begin
            cmd.link_prev = 1'b1;
            state_in      = S_RESP;
         end
         S_RECV: begin
            cmd.recv = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (flags.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- design/pmq_dpath.sv -----
`timescale 1ns / 1ps

module pmq_dpath
   import pmq_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output flags_type             flags
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int PTR_W  = $clog2(SLOTS + 1);
   localparam int MB_W   = $clog2(MAX_BYTES + 1);
   localparam int SZ_W   = (MB_W > 10) ? MB_W : 10;
   localparam int CMP_W  = (SZ_W > BUF_W) ? SZ_W : BUF_W;
   localparam int MW     = (PTR_W > MAXM_W) ? PTR_W : MAXM_W;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

   // item
   logic              mode_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [PAY_W-1:0]  pay_ff;
   logic [BUF_W-1:0]  buf_ff;

   // configuration
   logic [MAXM_W-1:0]  maxm_ff;
   logic [MSIZE_W-1:0] msize_ff;

   // list state
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] free_head_ff;
   logic [PTR_W-1:0] fresh_ff;
   logic [PTR_W-1:0] count_ff;
   logic [PTR_W-1:0] prev_ff;
   logic [PTR_W-1:0] cur_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             recycled_ff;
   status_type       status_ff;

   // result
   logic [PRIO_W-1:0]     out_prio_ff;
   logic [LEN_W-1:0]      out_len_ff;
   logic [PAY_W-1:0]      out_pay_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // slot memories
   logic [PTR_W-1:0]  next_mem [SLOTS];
   logic [PRIO_W-1:0] prio_mem [SLOTS];
   logic [LEN_W-1:0]  len_mem  [SLOTS];
   logic [PAY_W-1:0]  pay_mem  [SLOTS];
   logic [PTR_W-1:0]  rd_next_ff;
   logic [PRIO_W-1:0] rd_prio_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic [PAY_W-1:0]  rd_pay_ff;

   logic [IDX_W-1:0] rd_addr;
   logic             next_we;
   logic [IDX_W-1:0] next_waddr;
   logic [PTR_W-1:0] next_wdata;
   logic [IDX_W-1:0] alloc_slot;
   logic             data_we;

   logic [9:0]       size_round;
   logic [SZ_W-1:0]  eff_size;
   logic [CMP_W-1:0] eff_size_x;
   logic [MW-1:0]    eff_max;
   logic [MW-1:0]    count_x;
   status_type       status_calc;
   logic             prio_ge;

   // effective limits
   always_comb begin
      size_round = (10'(msize_ff) + 10'd7) & ~10'd7;
      if (SZ_W'(size_round) > SZ_W'(MAX_BYTES)) begin
         eff_size = SZ_W'(MAX_BYTES);
      end else begin
         eff_size = SZ_W'(size_round);
      end
      eff_size_x = CMP_W'(eff_size);
      if (MW'(maxm_ff) > MW'(SLOTS)) begin
         eff_max = MW'(SLOTS);
      end else begin
         eff_max = MW'(maxm_ff);
      end
      count_x = MW'(count_ff);
   end

   always_comb begin
      status_calc = STAT_OK;
      if (!mode_ff) begin
         if (CMP_W'(len_ff) > eff_size_x) begin
            status_calc = STAT_TOO_LONG;
         end else if (count_x >= eff_max) begin
            status_calc = STAT_FULL;
         end
      end else begin
         if (CMP_W'(buf_ff) < eff_size_x) begin
            status_calc = STAT_TOO_SMALL;
         end else if (count_ff == '0) begin
            status_calc = STAT_EMPTY;
         end
      end
   end

   assign alloc_slot = (free_head_ff != NIL) ? free_head_ff[IDX_W-1:0] : fresh_ff[IDX_W-1:0];
   assign data_we    = cmd.decide && !mode_ff && (status_calc == STAT_OK);
   assign prio_ge    = (rd_prio_ff >= prio_ff);

   always_comb begin
      flags.is_recv   = mode_ff;
      flags.err       = (status_calc != STAT_OK);
      flags.head_nil  = (head_ff == NIL);
      flags.walk_more = prio_ge && (rd_next_ff != NIL);
      flags.prev_nil  = (prev_ff == NIL);
      flags.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // memory port selection
   always_comb begin
      rd_addr = '0;
      if (cmd.decide) begin
         rd_addr = mode_ff ? head_ff[IDX_W-1:0] : free_head_ff[IDX_W-1:0];
      end else if (cmd.alloc) begin
         rd_addr = head_ff[IDX_W-1:0];
      end else if (cmd.walk) begin
         rd_addr = rd_next_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      next_we    = cmd.link || cmd.link_prev || cmd.recv;
      next_waddr = slot_ff;
      next_wdata = cur_ff;
      if (cmd.link_prev) begin
         next_waddr = prev_ff[IDX_W-1:0];
         next_wdata = PTR_W'(slot_ff);
      end else if (cmd.recv) begin
         next_waddr = head_ff[IDX_W-1:0];
         next_wdata = free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      rd_next_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         prio_mem[alloc_slot] <= prio_ff;
         len_mem[alloc_slot]  <= len_ff;
         pay_mem[alloc_slot]  <= pay_ff;
      end
      rd_prio_ff <= prio_mem[rd_addr];
      rd_len_ff  <= len_mem[rd_addr];
      rd_pay_ff  <= pay_mem[rd_addr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         maxm_ff  <= MAXM_W'(32);
         msize_ff <= MSIZE_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_MESSAGES: maxm_ff  <= csr_wdata[MAXM_W-1:0];
            CSR_MESSAGE_SIZE: msize_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff     <= req_tuser;
         prio_ff     <= req_tdata[14:0];
         len_ff      <= req_tdata[23:15];
         pay_ff      <= req_tdata[55:24];
         buf_ff      <= req_tdata[71:56];
         out_prio_ff <= '0;
         out_len_ff  <= '0;
         out_pay_ff  <= '0;
      end
      if (cmd.decide) begin
         status_ff   <= status_calc;
         slot_ff     <= alloc_slot;
         recycled_ff <= (free_head_ff != NIL);
      end
      if (cmd.alloc) begin
         prev_ff <= NIL;
         cur_ff  <= head_ff;
      end
      if (cmd.walk && prio_ge) begin
         prev_ff <= cur_ff;
         cur_ff  <= rd_next_ff;
      end
      if (cmd.recv) begin
         out_prio_ff <= rd_prio_ff;
         out_len_ff  <= rd_len_ff;
         out_pay_ff  <= rd_pay_ff;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {7'd0, count_x[COUNT_W-1:0], out_pay_ff, out_len_ff,
                         out_prio_ff, status_ff};
      end
   end

   // list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         free_head_ff <= NIL;
         fresh_ff     <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.alloc) begin
            if (recycled_ff) begin
               free_head_ff <= rd_next_ff;
            end else begin
               fresh_ff <= fresh_ff + PTR_W'(1);
            end
         end
         if (cmd.link) begin
            count_ff <= count_ff + PTR_W'(1);
            if (prev_ff == NIL) begin
               head_ff <= PTR_W'(slot_ff);
            end
         end
         if (cmd.recv) begin
            head_ff      <= rd_next_ff;
            free_head_ff <= head_ff;
            count_ff     <= count_ff - PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/priority_message_queue.sv -----
`timescale 1ns / 1ps
// channel | ports                    | carries
// req     | req_tvalid/tready/tdata/tuser | send or receive request, tuser = mode
// rsp     | rsp_tvalid/tready/tdata  | status, received message, message count
// csr     | csr_we/index/wdata       | max_messages (0), message_size (1)
//
// A request is taken in IDLE and checked in DECIDE; a rejected one goes on to RESP, a receive
// to RECV and RESP. A send goes to ALLOC and, when the list is not empty, to WALK over the
// stored messages of equal or higher priority (the list walk reads one slot per cycle), then
// to LINK, to LINK_PREV when it is not placed at the head, and to RESP. One request is in work
// at a time. Synchronous reset empties the queue; no memory clearing pass is needed.
// A finished result waits in the output register while the next request is taken.

module priority_message_queue
   import pmq_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // priority_req, length, payload, buffer_length
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, out_priority, out_length, out_payload, message_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type   cmd;
   flags_type flags;

   pmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   pmq_dpath #(
      .SLOTS     (SLOTS),
      .MAX_BYTES (MAX_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .flags      (flags)
   );

endmodule

// ----- test/pmq_checker.sv -----
`timescale 1ns / 1ps

module pmq_checker
   import pmq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    checked
);

   typedef struct packed {
      logic [BUF_W-1:0]  buf_len;
      logic [PAY_W-1:0]  payload;
      logic [LEN_W-1:0]  length;
      logic [PRIO_W-1:0] prio;
   } req_fields_type;

   typedef struct packed {
      logic [RSP_DATA_W-STATUS_W-PRIO_W-LEN_W-PAY_W-COUNT_W-1:0] pad;
      logic [COUNT_W-1:0] count;
      logic [PAY_W-1:0]   payload;
      logic [LEN_W-1:0]   length;
      logic [PRIO_W-1:0]  prio;
      status_type         status;
   } rsp_fields_type;

   typedef struct {
      logic [PRIO_W-1:0] prio;
      logic [LEN_W-1:0]  length;
      logic [PAY_W-1:0]  payload;
   } held_msg_type;

   held_msg_type   held[$];
   rsp_fields_type results_due[$];
   logic [MAXM_W-1:0]  limit_reg;
   logic [MSIZE_W-1:0] size_reg;

   function automatic int unsigned size_cap();
      int unsigned s;
      s = ((int'(size_reg) + 7) / 8) * 8;
      return (s > MAX_BYTES_DEF) ? MAX_BYTES_DEF : s;
   endfunction

   function automatic int unsigned slot_cap();
      return (limit_reg > SLOTS_DEF) ? SLOTS_DEF : limit_reg;
   endfunction

   // one operation on the sorted queue, returns the result it must produce
   function automatic rsp_fields_type serve_request(logic is_receive, req_fields_type r);
      rsp_fields_type res;
      held_msg_type   m;
      int             pos;
      res = '0;
      if (!is_receive) begin
         if (r.length > size_cap())
            res.status = STAT_TOO_LONG;
         else if (held.size() >= slot_cap())
            res.status = STAT_FULL;
         else begin
            m.prio    = r.prio;
            m.length  = r.length;
            m.payload = r.payload;
            pos = 0;
            while (pos < held.size() && held[pos].prio >= r.prio)
               pos++;
            held.insert(pos, m);
            res.status = STAT_OK;
         end
      end else begin
         if (r.buf_len < size_cap())
            res.status = STAT_TOO_SMALL;
         else if (held.size() == 0)
            res.status = STAT_EMPTY;
         else begin
            m           = held.pop_front();
            res.prio    = m.prio;
            res.length  = m.length;
            res.payload = m.payload;
            res.status  = STAT_OK;
         end
      end
      res.count = COUNT_W'(held.size());
      return res;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      if (mismatches < 40)
         $display("%0t mismatch in %s of result %0d: got 0x%0h, want 0x%0h",
                  $realtime, field, checked, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (reset) begin
         held.delete();
         results_due.delete();
         limit_reg  = MAXM_W'(SLOTS_DEF);
         size_reg   = MSIZE_W'(MAX_BYTES_DEF);
         mismatches = 0;
         checked    = 0;
      end else begin
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_MAX_MESSAGES: limit_reg = csr_wdata[MAXM_W-1:0];
               CSR_MESSAGE_SIZE: size_reg  = csr_wdata[MSIZE_W-1:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields_type'(rsp_tdata);
            if (results_due.size() == 0)
               report_mismatch("arrival (nothing pending)", 64'(got), 0);
            else begin
               want = results_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.prio !== want.prio)
                  report_mismatch("out_priority", got.prio, want.prio);
               if (got.length !== want.length)
                  report_mismatch("out_length", got.length, want.length);
               if (got.payload !== want.payload)
                  report_mismatch("out_payload", got.payload, want.payload);
               if (got.count !== want.count)
                  report_mismatch("message_count", got.count, want.count);
               if (got.pad !== want.pad)
                  report_mismatch("padding", got.pad, want.pad);
            end
            checked++;
         end
         if (req_tvalid && req_tready)
            results_due.push_back(serve_request(req_tuser, req_fields_type'(req_tdata)));
      end
      outstanding = results_due.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pmq_pkg::*;

   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_RECV = 1'b1;
   localparam int   QUIET_LIMIT = 1000;
   localparam int   PHASES = 10;
   localparam int   PHASE_ITEMS = 35;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int checked;
   int sends = 0;
   int receives = 0;
   int settings = 0;
   int quiet = 0;
   bit steady = 0;
   int unsigned cur_size = MAX_BYTES_DEF;

   int unsigned phase_max[PHASES]  = '{32, 1, 2, 0, 63, 33, 31, 5, 16, 8};
   int unsigned phase_size[PHASES] = '{256, 8, 0, 16, 511, 257, 7, 1, 255, 9};

   priority_message_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pmq_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet);
         $display("testbench: errors");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic int unsigned size_cap_of(int unsigned s);
      int unsigned r;
      r = ((s + 7) / 8) * 8;
      return (r > MAX_BYTES_DEF) ? MAX_BYTES_DEF : r;
   endfunction

   task automatic request(input logic mode, input logic [PRIO_W-1:0] prio,
                          input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] word,
                          input logic [BUF_W-1:0] buf_len);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {buf_len, word, len, prio};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_RECV)
         receives++;
      else
         sends++;
   endtask

   // hold off until every result is back, then let the block go idle
   task automatic settle(input int tail);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_limits(input int unsigned max_msgs, input int unsigned size);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_MESSAGES;
      csr_wdata <= CSR_DATA_W'(max_msgs);
      @(posedge clock);
      csr_index <= CSR_MESSAGE_SIZE;
      csr_wdata <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_size = size_cap_of(size);
      settings++;
   endtask

   initial begin
      int unsigned cap;
      int          send_pct;
      logic        mode;
      logic [PRIO_W-1:0] prio;
      logic [LEN_W-1:0]  len;
      logic [BUF_W-1:0]  buf_len;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_SEND;
      csr_we     = 1'b0;
      csr_index  = CSR_MAX_MESSAGES;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small buffer is reported before empty, then sends of edge lengths and priorities and receives
      request(MODE_RECV, 0, 0, 0, 16'd0);
      request(MODE_RECV, 0, 0, 0, 16'hFFFF);
      request(MODE_SEND, 9, 9'd257, 32'h1, 0);
      request(MODE_SEND, 9, 9'd511, 32'h2, 0);
      request(MODE_SEND, 15'd0, 9'd0, 32'h0, 0);
      request(MODE_SEND, 15'h7FFF, 9'd256, 32'hFFFF_FFFF, 0);
      request(MODE_SEND, 15'd5, 9'd8, 32'hA, 0);
      request(MODE_SEND, 15'd5, 9'd16, 32'hB, 0);
      request(MODE_SEND, 15'h7FFF, 9'd100, 32'hC, 0);
      request(MODE_RECV, 0, 0, 0, 16'd255);
      repeat (3) request(MODE_RECV, 0, 0, 0, 16'hFFFF);
      repeat (2) request(MODE_RECV, 0, 0, 0, 16'd256);
      request(MODE_RECV, 0, 0, 0, 16'd256);
      repeat (3) request(MODE_SEND, 15'($urandom), 9'd1, $urandom, 0);
      settle(12);

      // limit now below the count; size zero
      set_limits(2, 0);
      request(MODE_SEND, 15'd3, 9'd0, 32'h5, 0);
      request(MODE_SEND, 15'd3, 9'd1, 32'h6, 0);
      repeat (3) request(MODE_RECV, 0, 0, 0, 16'd0);
      repeat (3) request(MODE_SEND, 15'd4, 9'd0, $urandom, 0);
      settle(12);

      set_limits(0, 8);
      request(MODE_SEND, 15'd1, 9'd8, 32'h7, 0);
      request(MODE_SEND, 15'd1, 9'd9, 32'h8, 0);
      request(MODE_RECV, 0, 0, 0, 16'd7);
      repeat (2) request(MODE_RECV, 0, 0, 0, 16'd8);
      settle(12);

      for (int p = 0; p < PHASES + 2; p++) begin
         if (p < PHASES)
            set_limits(phase_max[p], phase_size[p]);
         else
            set_limits($urandom_range(0, 63), $urandom_range(0, 511));
         steady = (p % 3 == 1);
         cap = cur_size;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_pct = (i < PHASE_ITEMS / 2) ? 70 : 30;
            mode = ($urandom_range(0, 99) < send_pct) ? MODE_SEND : MODE_RECV;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: prio = 15'($urandom_range(0, 3));
               6, 7:             prio = 15'($urandom);
               8:                prio = 15'h7FFF;
               default:          prio = 15'd0;
            endcase
            if ($urandom_range(0, 9) < 8)
               len = 9'($urandom_range(0, cap));
            else
               len = 9'($urandom);
            if ($urandom_range(0, 9) < 8)
               buf_len = $urandom_range(0, 1) ? 16'(cap + $urandom_range(0, 7))
                                              : 16'($urandom_range(cap, 65535));
            else if (cap > 0)
               buf_len = 16'($urandom_range(0, cap - 1));
            else
               buf_len = 16'($urandom);
            request(mode, prio, len, $urandom, buf_len);
         end
         settle(12);
      end

      steady = 0;
      settle(50);
      $display("summary: %0d requests (%0d sends, %0d receives), %0d register settings",
               sends + receives, sends, receives, settings);
      $display("summary: %0d results checked, %0d mismatches", checked, mismatches);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
